[design/static_huffman_bit_decoder_assert.svh]
// Assertion macros for the static Huffman bit decoder checker.
`ifndef STATIC_HUFFMAN_BIT_DECODER_ASSERT_SVH
`define STATIC_HUFFMAN_BIT_DECODER_ASSERT_SVH

// Generic clocked assertion with active-low reset disable.
`define SHBD_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the aclk/aresetn domain.
`define SHBD_ASSERT(label, prop, msg) \
    `SHBD_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

[design/shbd_pkg.sv]
// Package with types, constants and the code tree ROM of the Huffman bit decoder.
`default_nettype none

package shbd_pkg;

    localparam int TREE_NODES   = 52;
    localparam int NODE_IDX_W   = $clog2(TREE_NODES);
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;
    localparam int COUNT_W      = 8;

    localparam logic [NODE_IDX_W-1:0] NULL_NODE = NODE_IDX_W'(0);
    localparam logic [NODE_IDX_W-1:0] ROOT_NODE = NODE_IDX_W'(1);

    localparam logic [COUNT_W-1:0] COUNT_MAX          = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] LETTER_LIMIT_RESET = {COUNT_W{1'b1}};
    localparam logic [LETTER_W-1:0] LAST_LETTER       = LETTER_W'(LETTER_COUNT - 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_LETTER_LIMIT = 1'b0;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] left;
        logic [NODE_IDX_W-1:0] right;
        logic                  is_leaf;
        logic [LETTER_W-1:0]   letter;
    } tree_node_t;

    typedef struct packed {
        logic code_bit;
        logic end_of_string;
    } item_t;

    typedef struct packed {
        logic                letter_valid;
        logic [LETTER_W-1:0] letter_index;
        logic                done_res;
        logic                ok;
    } result_t;

    function automatic tree_node_t branch(input int unsigned l, input int unsigned r);
        tree_node_t n;
        n.left    = NODE_IDX_W'(l);
        n.right   = NODE_IDX_W'(r);
        n.is_leaf = 1'b0;
        n.letter  = '0;
        return n;
    endfunction

    function automatic tree_node_t leaf(input int unsigned k);
        tree_node_t n;
        n.left    = NULL_NODE;
        n.right   = NULL_NODE;
        n.is_leaf = 1'b1;
        n.letter  = LETTER_W'(k);
        return n;
    endfunction

    // node 0 is the missing child, node 1 the root
    function automatic tree_node_t tree_rom(input logic [NODE_IDX_W-1:0] idx);
        tree_node_t n;
        unique case (idx)
            6'd1:  n = branch(2, 5);
            6'd2:  n = branch(3, 18);
            6'd3:  n = branch(4, 11);
            6'd4:  n = leaf(0);
            6'd5:  n = branch(6, 14);
            6'd6:  n = branch(42, 7);
            6'd7:  n = branch(8, 33);
            6'd8:  n = branch(9, 36);
            6'd9:  n = branch(47, 10);
            6'd10: n = leaf(1);
            6'd11: n = branch(12, 25);
            6'd12: n = branch(23, 13);
            6'd13: n = leaf(2);
            6'd14: n = branch(15, 34);
            6'd15: n = branch(26, 16);
            6'd16: n = branch(31, 17);
            6'd17: n = leaf(3);
            6'd18: n = branch(20, 19);
            6'd19: n = leaf(4);
            6'd20: n = branch(21, 41);
            6'd21: n = branch(22, 32);
            6'd22: n = leaf(5);
            6'd23: n = branch(27, 24);
            6'd24: n = leaf(6);
            6'd25: n = leaf(7);
            6'd26: n = leaf(8);
            6'd27: n = branch(30, 28);
            6'd28: n = branch(38, 29);
            6'd29: n = leaf(9);
            6'd30: n = leaf(10);
            6'd31: n = leaf(11);
            6'd32: n = leaf(12);
            6'd33: n = leaf(13);
            6'd34: n = branch(35, 44);
            6'd35: n = leaf(14);
            6'd36: n = branch(48, 37);
            6'd37: n = leaf(15);
            6'd38: n = branch(39, 49);
            6'd39: n = branch(51, 40);
            6'd40: n = leaf(16);
            6'd41: n = leaf(17);
            6'd42: n = branch(43, 45);
            6'd43: n = leaf(18);
            6'd44: n = leaf(19);
            6'd45: n = branch(50, 46);
            6'd46: n = leaf(20);
            6'd47: n = leaf(21);
            6'd48: n = leaf(22);
            6'd49: n = leaf(23);
            6'd50: n = leaf(24);
            6'd51: n = leaf(25);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[design/shbd_apb.sv]
// APB register block holding the letter limit.
`default_nettype none

module shbd_apb (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [shbd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [shbd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [shbd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [shbd_pkg::COUNT_W-1:0]     letter_limit
);

    logic [shbd_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;
    logic [shbd_pkg::COUNT_W-1:0]   limit_reg;
    logic [shbd_pkg::COUNT_W-1:0]   limit_next;

    assign reg_idx = paddr[shbd_pkg::APB_ADDR_W-1 -: shbd_pkg::REG_IDX_W];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        limit_next = limit_reg;
        if (wr_en && reg_idx == shbd_pkg::REG_LETTER_LIMIT) begin
            limit_next = pwdata[shbd_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= shbd_pkg::LETTER_LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == shbd_pkg::REG_LETTER_LIMIT) begin
            prdata = shbd_pkg::APB_DATA_W'(limit_reg);
        end
    end

    assign letter_limit = limit_reg;

endmodule

`default_nettype wire

[design/shbd_walk.sv]
// Tree walk state, one-bit decode step and result register.
`default_nettype none

module shbd_walk #(
    parameter int NODE_SLOTS = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    input  wire shbd_pkg::item_t               item,
    output logic                               item_ready,
    input  wire logic [shbd_pkg::COUNT_W-1:0]  letter_limit,
    output logic                               res_valid,
    output shbd_pkg::result_t                  res,
    input  wire logic                          res_ready
);

    localparam int NODE_W = $clog2(NODE_SLOTS);

    logic [NODE_W-1:0]               cur_node_reg, cur_node_next;
    logic [shbd_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            halted_reg, halted_next;
    logic                            res_vld_reg, res_vld_next;
    shbd_pkg::result_t               res_reg, res_next;

    logic                            res_free;
    logic                            step;
    logic                            node_in_rom;
    shbd_pkg::tree_node_t            cur_entry;
    logic [shbd_pkg::NODE_IDX_W-1:0] child_idx;
    shbd_pkg::tree_node_t            child_entry;
    logic                            hit;
    logic [shbd_pkg::NODE_IDX_W-1:0] walk_node;
    logic [shbd_pkg::COUNT_W-1:0]    count_bump;
    logic                            stop;
    logic                            at_root;

    assign res_free   = !res_vld_reg || res_ready;
    assign item_ready = res_free;
    assign step       = item_valid && res_free;

    assign node_in_rom = cur_node_reg < NODE_W'(shbd_pkg::TREE_NODES);
    assign cur_entry   = node_in_rom ?
                         shbd_pkg::tree_rom(cur_node_reg[shbd_pkg::NODE_IDX_W-1:0]) : '0;
    assign child_idx   = item.code_bit ? cur_entry.right : cur_entry.left;
    assign child_entry = shbd_pkg::tree_rom(child_idx);
    assign hit         = (child_idx != shbd_pkg::NULL_NODE) && child_entry.is_leaf;
    assign walk_node   = hit ? shbd_pkg::ROOT_NODE : child_idx;

    always_comb begin
        count_bump = count_reg;
        if (hit && count_reg != shbd_pkg::COUNT_MAX) begin
            count_bump = count_reg + 1'b1;
        end
    end

    assign stop    = (count_bump >= letter_limit) || (walk_node == shbd_pkg::NULL_NODE);
    assign at_root = walk_node == shbd_pkg::ROOT_NODE;

    always_comb begin
        cur_node_next = cur_node_reg;
        count_next    = count_reg;
        halted_next   = halted_reg;
        res_next      = '0;
        if (!halted_reg) begin
            cur_node_next         = NODE_W'(walk_node);
            count_next            = count_bump;
            res_next.letter_valid = hit;
            res_next.letter_index = hit ? child_entry.letter : '0;
            if (stop) begin
                halted_next       = 1'b1;
                res_next.done_res = 1'b1;
                res_next.ok       = at_root;
            end else if (item.end_of_string) begin
                res_next.done_res = 1'b1;
                res_next.ok       = at_root;
            end
        end
        // end mark re-arms the walk for the next string
        if (item.end_of_string) begin
            cur_node_next = NODE_W'(shbd_pkg::ROOT_NODE);
            count_next    = '0;
            halted_next   = 1'b0;
        end
    end

    always_comb begin
        res_vld_next = res_vld_reg;
        if (step) begin
            res_vld_next = 1'b1;
        end else if (res_ready) begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_node_reg <= NODE_W'(shbd_pkg::ROOT_NODE);
            count_reg    <= '0;
            halted_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
        end else begin
            res_vld_reg <= res_vld_next;
            if (step) begin
                cur_node_reg <= cur_node_next;
                count_reg    <= count_next;
                halted_reg   <= halted_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[design/static_huffman_bit_decoder.sv]
// Top level of the static Huffman bit decoder: input register, walk and APB port.
// Path: the input transfer is held in the input register, then the walk result in the result register.
// Throughput: one bit per cycle while the result channel is not stalled; the tree ROM lookups and
// state update are combinational between the two registers.
// Reset (aresetn low, synchronous): walk at root, letter count 0, not halted,
// letter_limit 255, both channels empty.
`default_nettype none

module static_huffman_bit_decoder #(
    parameter int NODE_SLOTS = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_code_bit,
    input  wire logic                                  s_end_of_string,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_letter_valid,
    output logic      [shbd_pkg::LETTER_W-1:0]         m_letter_index,
    output logic                                       m_done_res,
    output logic                                       m_ok,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [shbd_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [shbd_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [shbd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                       pready
);

    logic                         in_vld_reg, in_vld_next;
    shbd_pkg::item_t              in_item_reg;
    logic                         walk_ready;
    logic                         in_xfer;
    logic [shbd_pkg::COUNT_W-1:0] letter_limit;
    shbd_pkg::result_t            res;

    assign s_ready = !in_vld_reg || walk_ready;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_xfer) begin
            in_vld_next = 1'b1;
        end else if (walk_ready) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg.code_bit      <= s_code_bit;
            in_item_reg.end_of_string <= s_end_of_string;
        end
    end

    shbd_apb u_apb (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .letter_limit (letter_limit)
    );

    shbd_walk #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (in_vld_reg),
        .item         (in_item_reg),
        .item_ready   (walk_ready),
        .letter_limit (letter_limit),
        .res_valid    (m_valid),
        .res          (res),
        .res_ready    (m_ready)
    );

    assign m_letter_valid = res.letter_valid;
    assign m_letter_index = res.letter_index;
    assign m_done_res     = res.done_res;
    assign m_ok           = res.ok;

endmodule

`default_nettype wire

[design/shbd_checker.sv]
// Port-level checker for the static Huffman bit decoder and its bind.
`default_nettype none

`include "static_huffman_bit_decoder_assert.svh"

module shbd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_letter_valid,
    input wire logic [shbd_pkg::LETTER_W-1:0] m_letter_index,
    input wire logic                          m_done_res,
    input wire logic                          m_ok
);

    `SHBD_ASSERT(a_index_zero_idle, m_valid && !m_letter_valid |-> m_letter_index == '0, "letter_index set without letter_valid")
    `SHBD_ASSERT(a_index_range, m_valid && m_letter_valid |-> m_letter_index <= shbd_pkg::LAST_LETTER, "letter_index out of range")
    `SHBD_ASSERT(a_ok_needs_done, m_valid && m_ok |-> m_done_res, "ok without done")
    `SHBD_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable({m_letter_valid, m_letter_index, m_done_res, m_ok}), "stalled result transfer changed")

endmodule

bind static_huffman_bit_decoder shbd_checker u_shbd_checker (.*);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the static Huffman bit decoder: streams, limits, stalls.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W         = shbd_pkg::APB_ADDR_W;
    localparam int DATA_W         = shbd_pkg::APB_DATA_W;
    localparam int LTR_W          = shbd_pkg::LETTER_W;
    localparam int N_LETTERS      = shbd_pkg::LETTER_COUNT;
    localparam int SLOTS          = 64;
    localparam int WALK_ROOT      = 1;
    localparam int WALK_NULL      = 0;
    localparam int COUNT_SAT      = 255;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_AT        = 450;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * shbd_pkg::REG_LETTER_LIMIT);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_code_bit = 1'b0;
    logic                  s_end_of_string = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_letter_valid;
    logic [LTR_W-1:0]      m_letter_index;
    logic                  m_done_res;
    logic                  m_ok;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    static_huffman_bit_decoder #(.NODE_SLOTS(SLOTS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_code_bit(s_code_bit), .s_end_of_string(s_end_of_string),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_letter_valid(m_letter_valid), .m_letter_index(m_letter_index),
        .m_done_res(m_done_res), .m_ok(m_ok),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // prefix code, MSB first
    int       code_len [N_LETTERS];
    bit [9:0] code_val [N_LETTERS];

    int       node_left  [SLOTS];
    int       node_right [SLOTS];
    bit       node_leaf  [SLOTS];
    int       node_char  [SLOTS];

    int       walk_node;
    int       letters_done;
    bit       walk_halted;
    int       letter_limit_q;

    shbd_pkg::item_t    pending_bits [$];
    shbd_pkg::result_t  expected_results [$];
    shbd_pkg::item_t    next_bit;

    int       items_queued = 0;
    int       bits_accepted = 0;
    int       results_seen = 0;
    int       letters_seen = 0;
    int       strings_clean = 0;
    int       strings_failed = 0;
    int       limits_used = 0;
    int       error_count = 0;
    int       quiet_cycles = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    bit       idle_on = 1'b1;

    function automatic void build_code_tree();
        int  node;
        int  slot;
        bit  complete;
        int  next_free;
        next_free = WALK_ROOT + 1;
        for (int n = 0; n < SLOTS; n++) begin
            node_left[n]  = WALK_NULL;
            node_right[n] = WALK_NULL;
            node_leaf[n]  = 1'b0;
            node_char[n]  = 0;
        end
        for (int k = 0; k < N_LETTERS; k++) begin
            node = WALK_ROOT;
            complete = 1'b1;
            for (int b = code_len[k] - 1; b >= 0; b--) begin
                slot = code_val[k][b] ? node_right[node] : node_left[node];
                if (slot == WALK_NULL) begin
                    if (next_free >= SLOTS) begin
                        complete = 1'b0;
                        break;
                    end
                    slot = next_free;
                    next_free++;
                    if (code_val[k][b]) node_right[node] = slot;
                    else node_left[node] = slot;
                end
                node = slot;
            end
            if (complete && node != WALK_ROOT) begin
                node_leaf[node] = 1'b1;
                node_char[node] = k;
            end
        end
    endfunction

    function automatic shbd_pkg::result_t decode_bit(input bit code, input bit last);
        shbd_pkg::result_t r;
        int      nxt;
        r = '0;
        if (!walk_halted) begin
            nxt = code ? node_right[walk_node] : node_left[walk_node];
            if (nxt >= SLOTS) nxt = WALK_NULL;
            if (nxt != WALK_NULL && node_leaf[nxt]) begin
                r.letter_valid = 1'b1;
                r.letter_index = LTR_W'(node_char[nxt]);
                nxt = WALK_ROOT;
                if (letters_done < COUNT_SAT) letters_done++;
            end
            walk_node = nxt;
            if (letters_done >= letter_limit_q || nxt == WALK_NULL) begin
                walk_halted = 1'b1;
                r.done_res = 1'b1;
                r.ok = (nxt == WALK_ROOT);
            end else if (last) begin
                r.done_res = 1'b1;
                r.ok = (nxt == WALK_ROOT);
            end
        end
        if (last) begin
            walk_node = WALK_ROOT;
            letters_done = 0;
            walk_halted = 1'b0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_bit(input bit code, input bit last);
        shbd_pkg::item_t it;
        it.code_bit = code;
        it.end_of_string = last;
        pending_bits.push_back(it);
        items_queued++;
    endtask

    task automatic queue_letter(input int k, input bit last);
        for (int b = code_len[k] - 1; b >= 0; b--)
            queue_bit(code_val[k][b], last && b == 0);
    endtask

    // mostly whole strings; some cut inside a code, some raw noise
    task automatic queue_random_string();
        int kind;
        int n;
        int k;
        int p;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) queue_letter($urandom_range(0, 25), i == n - 1);
        end else if (kind < 85) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) queue_letter($urandom_range(0, 25), 1'b0);
            k = $urandom_range(0, 25);
            p = $urandom_range(1, code_len[k] - 1);
            for (int j = 0; j < p; j++) queue_bit(code_val[k][code_len[k] - 1 - j], j == p - 1);
        end else begin
            n = $urandom_range(1, 12);
            for (int j = 0; j < n; j++) queue_bit($urandom_range(0, 1), j == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (bits_accepted != items_queued || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_limit(input int value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        letter_limit_q = value & 8'hFF;
        limits_used++;
    endtask

    task automatic run_phase(input int limit, input int n_items, input bit gaps);
        int target;
        write_limit(limit);
        idle_on = gaps;
        target = items_queued + n_items;
        while (items_queued < target) queue_random_string();
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(decode_bit(s_code_bit, s_end_of_string));
                bits_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bits.size() > 0) begin
                    next_bit = pending_bits.pop_front();
                    s_valid <= 1'b1;
                    s_code_bit <= next_bit.code_bit;
                    s_end_of_string <= next_bit.end_of_string;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : rx
        shbd_pkg::result_t got;
        shbd_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                got = {m_letter_valid, m_letter_index, m_done_res, m_ok};
                if (got.letter_valid) letters_seen++;
                if (got.done_res && got.ok) strings_clean++;
                if (got.done_res && !got.ok) strings_failed++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected: valid=%0b letter=%0d done=%0b ok=%0b",
                             $time, got.letter_valid, got.letter_index, got.done_res, got.ok);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        error_count++;
                        $display("%0t: mismatch expected valid=%0b letter=%0d done=%0b ok=%0b",
                                 $time, want.letter_valid, want.letter_index, want.done_res,
                                 want.ok);
                        $display("%0t:          actual   valid=%0b letter=%0d done=%0b ok=%0b",
                                 $time, got.letter_valid, got.letter_index, got.done_res, got.ok);
                    end
                end
                if (stall_left == 0) stall_left = pick_gap();
            end
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        code_len = '{3, 6, 5, 5, 3, 5, 6, 4, 4, 8, 7, 5, 5,
                     4, 4, 6, 10, 4, 4, 4, 5, 6, 6, 9, 5, 10};
        code_val = '{10'd0, 10'd41, 10'd5, 10'd27, 10'd3, 10'd8, 10'd9, 10'd3, 10'd12,
                     10'd35, 10'd16, 10'd26, 10'd9, 10'd11, 10'd14, 10'd43, 10'd137,
                     10'd5, 10'd8, 10'd15, 10'd19, 10'd40, 10'd42, 10'd69, 10'd18,
                     10'd136};
        build_code_tree();
        walk_node = WALK_ROOT;
        letters_done = 0;
        walk_halted = 1'b0;
        letter_limit_q = COUNT_SAT;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: shortest and deepest codes, string cut inside a code, lone bit
        queue_letter(0, 1'b1);
        queue_letter(25, 1'b1);
        queue_bit(1'b0, 1'b0);
        queue_bit(1'b1, 1'b1);
        queue_bit(1'b1, 1'b1);

        // limit 0: first bit stops, later bits ignored, end mark only re-arms
        write_limit(0);
        queue_bit(1'b1, 1'b1);
        queue_bit(1'b0, 1'b0);
        queue_bit(1'b1, 1'b0);
        queue_bit(1'b1, 1'b1);

        // limit 1: stop at the root after one letter
        write_limit(1);
        queue_letter(4, 1'b0);
        queue_letter(0, 1'b1);

        run_phase(2, 140, 1'b1);
        run_phase(0, 60, 1'b0);
        run_phase(1, 120, 1'b1);
        run_phase(COUNT_SAT, 160, 1'b0);
        run_phase($urandom_range(3, 9), 140, 1'b1);
        run_phase(5, 140, 1'b1);
        run_phase(COUNT_SAT, 200, 1'b1);
        run_phase(3, 120, 1'b0);

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Covered %0d bits over %0d limit settings: %0d letters, %0d clean and %0d bad ends",
                 bits_accepted, limits_used, letters_seen, strings_clean, strings_failed);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", error_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
